// ----- rtl/smtc_pkg.sv -----
`default_nettype none

package smtc_pkg;

  // Sweep length and field widths
  localparam int SWEEP_STEPS  = 100;
  localparam int STEP_W       = 8;
  localparam int MAG_W        = 12;
  localparam int LEVEL_W      = 6;
  localparam int PCT_W        = 7;
  localparam int FAIL_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // Mask anchors: step position and expected level
  localparam int ANCHOR_COUNT = 9;
  localparam logic [STEP_W-1:0]  MASK_STEPS  [ANCHOR_COUNT] =
    '{0, 30, 32, 36, 41, 50, 60, 75, 99};
  localparam logic [LEVEL_W-1:0] MASK_LEVELS [ANCHOR_COUNT] =
    '{0, 0, 24, 50, 53, 45, 31, 20, 15};

  // Serial divider: |delta| * offset over segment span
  localparam int DVD_W = 10;
  localparam int DVS_W = 5;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // Percent scaling: x / 100 == (x * 5243) >> 19 for x < 43690
  localparam int PROD_W     = LEVEL_W + PCT_W;
  localparam int RECIP_W    = 13;
  localparam int RPROD_W    = PROD_W + RECIP_W;
  localparam int PCT_SHIFT  = 19;
  localparam int SCALED_W   = RPROD_W - PCT_SHIFT;
  localparam logic [RECIP_W-1:0] PCT_RECIP = 13'd5243;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TOL   = 2'd0,
    CFG_TOL_PCT   = 2'd1,
    CFG_MAX_FAILS = 2'd2
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] MIN_TOL_RST   = 12'd8;
  localparam logic [PCT_W-1:0]      TOL_PCT_RST   = 7'd20;
  localparam logic [FAIL_W-1:0]     MAX_FAILS_RST = 8'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic fix;
    logic mul_pct;
    logic mul_recip;
    logic judge;
    logic commit;
  } smtc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } smtc_sts_t;

  // One mask segment, ready for the divider
  typedef struct packed {
    logic [LEVEL_W-1:0] base;
    logic               neg;
    logic [DVD_W-1:0]   prod;
    logic [DVS_W-1:0]   span;
  } seg_t;

  // Pick the first segment whose end is at or past the step.
  // Past the last anchor: level holds at the final anchor.
  function automatic seg_t mask_segment(input logic [STEP_W-1:0] step);
    seg_t seg;
    logic found;
    int   delta;
    int   off;
    int   mag;
    seg.base = MASK_LEVELS[ANCHOR_COUNT-1];
    seg.neg  = 1'b0;
    seg.prod = '0;
    seg.span = DVS_W'(1);
    found    = 1'b0;
    for (int k = 0; k < ANCHOR_COUNT - 1; k++) begin
      if (!found && (int'(step) <= int'(MASK_STEPS[k+1]))) begin
        found    = 1'b1;
        off      = int'(step) - int'(MASK_STEPS[k]);
        delta    = int'(MASK_LEVELS[k+1]) - int'(MASK_LEVELS[k]);
        mag      = (delta < 0) ? -delta : delta;
        seg.base = MASK_LEVELS[k];
        seg.neg  = (delta < 0);
        seg.prod = DVD_W'(mag * off);
        seg.span = DVS_W'(int'(MASK_STEPS[k+1]) - int'(MASK_STEPS[k]));
      end
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/smtc_in_if.sv -----
`default_nettype none

interface smtc_in_if import smtc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink   (input valid, input magnitude, output ready);
endinterface

`default_nettype wire

// ----- rtl/smtc_out_if.sv -----
`default_nettype none

interface smtc_out_if import smtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STEP_W-1:0]  step_number;
  logic [LEVEL_W-1:0] expected_level;
  logic               step_failed;
  logic [FAIL_W-1:0]  failures_so_far;
  logic               sweep_done;
  logic               sweep_pass;

  modport source (output valid, output step_number, output expected_level,
                  output step_failed, output failures_so_far, output sweep_done,
                  output sweep_pass, input ready);
  modport sink   (input valid, input step_number, input expected_level,
                  input step_failed, input failures_so_far, input sweep_done,
                  input sweep_pass, output ready);
endinterface

`default_nettype wire

// ----- rtl/smtc_cfg_if.sv -----
`default_nettype none

interface smtc_cfg_if import smtc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/smtc_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle
module smtc_div import smtc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DVD_W-1:0]     dq;
  logic [DVS_W:0]       trial;
  logic                 fits;
  logic [DVS_W-1:0]     rem_next;

  // trial subtract
  always_comb begin
    trial    = {rem, dq[DVD_W-1]};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
  end

  // iteration count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (start) begin
        cnt <= DIV_CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // remainder and dividend/quotient shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      dq  <= {dq[DVD_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

`default_nettype wire

// ----- rtl/smtc_ctrl.sv -----
`default_nettype none

module smtc_ctrl import smtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output smtc_cmd_t  cmd,
  input  smtc_sts_t  sts
);

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    MUL_PCT,
    MUL_RECIP,
    JUDGE,
    COMMIT
  } state_t;

  state_t state;

  // commands decoded from state
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == IDLE) && in_valid;
    cmd.fix       = (state == DIVIDE) && sts.div_done;
    cmd.mul_pct   = (state == MUL_PCT);
    cmd.mul_recip = (state == MUL_RECIP);
    cmd.judge     = (state == JUDGE);
    cmd.commit    = (state == COMMIT) && (!out_valid || out_ready);
  end

  assign in_ready = (state == IDLE);

  // state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE:      if (cmd.load)   state <= DIVIDE;
        DIVIDE:    if (cmd.fix)    state <= MUL_PCT;
        MUL_PCT:   state <= MUL_RECIP;
        MUL_RECIP: state <= JUDGE;
        JUDGE:     state <= COMMIT;
        COMMIT:    if (cmd.commit) state <= IDLE;
        default:   state <= IDLE;
      endcase
    end
  end

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.commit)
    else $error("result overwritten while stalled");

  // a beat is accepted only with no item in flight
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == DIVIDE) && !in_ready)
    else $error("input taken while busy");

  // commit always hands over a valid result
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && in_ready)
    else $error("commit did not raise valid");

endmodule

`default_nettype wire

// ----- rtl/smtc_dp.sv -----
`default_nettype none

module smtc_dp import smtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  smtc_cmd_t             cmd,
  output smtc_sts_t             sts,
  input  logic [MAG_W-1:0]      magnitude,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [STEP_W-1:0]     step_number,
  output logic [LEVEL_W-1:0]    expected_level,
  output logic                  step_failed,
  output logic [FAIL_W-1:0]     failures_so_far,
  output logic                  sweep_done,
  output logic                  sweep_pass
);

  // config registers
  logic [CFG_DATA_W-1:0] min_tol;
  logic [PCT_W-1:0]      tol_pct;
  logic [FAIL_W-1:0]     max_fails;

  // sweep state
  logic [STEP_W-1:0]     step_cnt;
  logic [FAIL_W-1:0]     fail_cnt;

  // per item working registers
  logic [MAG_W-1:0]      meas;
  logic [LEVEL_W-1:0]    seg_base;
  logic                  seg_neg;
  logic [LEVEL_W-1:0]    expected;
  logic [PROD_W-1:0]     prod_pct;
  logic [SCALED_W-1:0]   scaled;
  logic                  j_failed;
  logic [FAIL_W-1:0]     j_fails;
  logic                  j_done;
  logic                  j_ok;

  seg_t                  seg;
  logic                  div_done;
  logic [DVD_W-1:0]      quotient;
  logic [LEVEL_W:0]      q_ext;
  logic [LEVEL_W:0]      level;
  logic [RPROD_W-1:0]    recip_full;
  logic [MAG_W-1:0]      exp_ext;
  logic [MAG_W-1:0]      diff;
  logic [CFG_DATA_W-1:0] scaled_ext;
  logic [CFG_DATA_W-1:0] tol;
  logic                  failed;
  logic [FAIL_W-1:0]     fails_new;
  logic                  done_now;

  // segment of the mask for the current step
  assign seg = mask_segment(step_cnt);

  smtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (seg.prod),
    .divisor  (seg.span),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.div_done = div_done;

  // base plus or minus truncated quotient
  always_comb begin
    q_ext = quotient[LEVEL_W:0];
    level = seg_neg ? ({1'b0, seg_base} - q_ext) : ({1'b0, seg_base} + q_ext);
  end

  assign recip_full = RPROD_W'(prod_pct) * RPROD_W'(PCT_RECIP);

  // tolerance compare and failure count
  always_comb begin
    exp_ext    = MAG_W'(expected);
    diff       = (meas > exp_ext) ? (meas - exp_ext) : (exp_ext - meas);
    scaled_ext = CFG_DATA_W'(scaled);
    tol        = (scaled_ext > min_tol) ? scaled_ext : min_tol;
    failed     = (diff > MAG_W'(tol));
    fails_new  = (failed && (fail_cnt != '1)) ? fail_cnt + 1'b1 : fail_cnt;
    done_now   = (step_cnt == STEP_W'(SWEEP_STEPS - 1));
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_tol   <= MIN_TOL_RST;
      tol_pct   <= TOL_PCT_RST;
      max_fails <= MAX_FAILS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_TOL:   min_tol   <= cfg_data;
        CFG_TOL_PCT:   tol_pct   <= cfg_data[PCT_W-1:0];
        CFG_MAX_FAILS: max_fails <= cfg_data[FAIL_W-1:0];
        default:       ;
      endcase
    end
  end

  // step and failure counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      fail_cnt <= '0;
    end else if (cmd.commit) begin
      step_cnt <= j_done ? '0 : step_cnt + 1'b1;
      fail_cnt <= j_done ? '0 : j_fails;
    end
  end

  // working pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas     <= magnitude;
      seg_base <= seg.base;
      seg_neg  <= seg.neg;
    end
    if (cmd.fix) begin
      expected <= level[LEVEL_W-1:0];
    end
    if (cmd.mul_pct) begin
      prod_pct <= PROD_W'(expected) * PROD_W'(tol_pct);
    end
    if (cmd.mul_recip) begin
      scaled <= recip_full[PCT_SHIFT +: SCALED_W];
    end
    if (cmd.judge) begin
      j_failed <= failed;
      j_fails  <= fails_new;
      j_done   <= done_now;
      j_ok     <= done_now && (fails_new <= max_fails);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      step_number     <= step_cnt;
      expected_level  <= expected;
      step_failed     <= j_failed;
      failures_so_far <= j_fails;
      sweep_done      <= j_done;
      sweep_pass      <= j_ok;
    end
  end

  // verdict only on the last step
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (!sweep_pass || sweep_done))
    else $error("sweep_pass outside final step");

  // sweep end clears both counters
  assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && j_done) |=> (step_cnt == '0) && (fail_cnt == '0))
    else $error("counters not cleared at sweep end");

  // steps advance by one inside a sweep
  assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !j_done) |=> (step_cnt == STEP_W'($past(step_cnt) + 1'b1)))
    else $error("step counter skipped");

  // a failing step always shows a nonzero count
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (!step_failed || (failures_so_far != '0)))
    else $error("failed step with zero count");

endmodule

`default_nettype wire

// ----- rtl/sweep_mask_tolerance_checker.sv -----
// Sweep mask tolerance checker.
// sample (valid/ready): one averaged 12-bit magnitude per sweep step; the step
//   index is counted inside the block, starting at 0 after reset.
// result (valid/ready): one beat per sample: step index, interpolated mask
//   level, fail flag, saturating failure count, and on the last step the
//   sweep_done flag with the sweep_pass verdict. Both counters then restart.
// cfg (valid/ready, always ready): index 0 minimum tolerance, 1 tolerance
//   percent, 2 allowed failures; other indexes are dropped. Write only while
//   no sample is in flight.
// Flow: a sample is accepted in the idle state, the mask level comes from a
//   serial restoring divide, then two multiply stages, a compare stage and the
//   result commit. One sample is in flight at a time: the next is accepted
//   only after the commit, which can itself wait on a stalled result.
// Stall: the result sits in an output register; the next sample is accepted
//   and processed while it waits, and only the commit of that next result
//   waits until the earlier beat is taken.
// Reset (rst, synchronous): counters cleared, registers at 8 / 20 / 5.
`default_nettype none

module sweep_mask_tolerance_checker import smtc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  smtc_in_if.sink   sample,
  smtc_out_if.source result,
  smtc_cfg_if.sink  cfg
);

  smtc_cmd_t cmd;
  smtc_sts_t sts;

  assign cfg.ready = 1'b1;

  smtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  smtc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .magnitude       (sample.magnitude),
    .cfg_write       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .step_number     (result.step_number),
    .expected_level  (result.expected_level),
    .step_failed     (result.step_failed),
    .failures_so_far (result.failures_so_far),
    .sweep_done      (result.sweep_done),
    .sweep_pass      (result.sweep_pass)
  );

endmodule

`default_nettype wire
